### hw/rtl/merge_sorter_core_assert.svh
// Assertion macros shared by the merge sorter modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef MERGE_SORTER_CORE_ASSERT_SVH
`define MERGE_SORTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset.
`define MSORT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("merge sorter check failed");

// Check that a condition in one cycle implies an expression in the next.
`define MSORT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("merge sorter sequencing check failed");

`else

`define MSORT_ASSERT(label, clk, rst_n, prop)
`define MSORT_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

### hw/rtl/msort_pkg.sv
package msort_pkg;

    // Width of one element word
    localparam int DATA_W = 32;

    // Input word
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    // Result word
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     truncated;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted element
        logic sort_init;   // width 1, data in store A
        logic run_first;   // first run of a pass
        logic run_init;    // set read and write pointers for a run
        logic run_next;    // advance to the next run
        logic pass_end;    // double width, swap stores
        logic merge_step;  // write one merged element
        logic emit_init;   // restart read pointer for emission
        logic emit_out;    // present one result
        logic set_clear;   // drop count and overflow flag
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pass_open;   // run width below element count
        logic run_open;    // run start below element count
        logic merge_open;  // write pointer below run end
        logic emit_last;   // read pointer on the final element
    } stat_t;

endpackage

### hw/rtl/msort_dp.sv
`include "merge_sorter_core_assert.svh"

module msort_dp #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msort_pkg::cmd_t   cmd,
    input  msort_pkg::item_t  item,
    output msort_pkg::stat_t  stat,
    output logic              strobe,
    output msort_pkg::result_t result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 2;

    // Two ping-pong stores, each with two registered read ports
    logic signed [msort_pkg::DATA_W-1:0] store_a_reg [DEPTH];
    logic signed [msort_pkg::DATA_W-1:0] store_b_reg [DEPTH];
    logic signed [msort_pkg::DATA_W-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;

    logic [CW-1:0] count_reg;
    logic          overflow_reg;
    logic          src_reg;        // 0: data in store A, 1: data in store B
    logic [IW-1:0] w_reg, lo_reg, i_reg, j_reg, k_reg;

    logic              strobe_reg;
    msort_pkg::result_t result_reg;

    logic [IW-1:0] n_ext, lo_w, lo_2w, mid, hi;
    logic signed [msort_pkg::DATA_W-1:0] left_data, right_data, merge_data;
    logic          take_left;
    logic          store_room;

    // Run bounds clipped to the element count
    always_comb
    begin
        n_ext = IW'(count_reg);
        lo_w  = lo_reg + w_reg;
        lo_2w = lo_reg + (w_reg << 1);
        mid   = (lo_w  < n_ext) ? lo_w  : n_ext;
        hi    = (lo_2w < n_ext) ? lo_2w : n_ext;
    end

    // Pick the smaller head, left run first on ties
    always_comb
    begin
        left_data  = src_reg ? rd_b0_reg : rd_a0_reg;
        right_data = src_reg ? rd_b1_reg : rd_a1_reg;
        take_left  = (i_reg < mid) && ((j_reg >= hi) || (left_data <= right_data));
        merge_data = take_left ? left_data : right_data;
        store_room = (count_reg < CW'(DEPTH));
    end

    always_comb
    begin
        stat.pass_open  = (w_reg < n_ext);
        stat.run_open   = (lo_reg < n_ext);
        stat.merge_open = (k_reg < hi);
        stat.emit_last  = ((i_reg + IW'(1)) == n_ext);
    end

    // Store A: loading and merge writes; two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load && store_room)
        begin
            store_a_reg[count_reg[AW-1:0]] <= item.value;
        end
        else if (cmd.merge_step && src_reg)
        begin
            store_a_reg[k_reg[AW-1:0]] <= merge_data;
        end
        rd_a0_reg <= store_a_reg[i_reg[AW-1:0]];
        rd_a1_reg <= store_a_reg[j_reg[AW-1:0]];
    end

    // Store B: merge writes only; two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.merge_step && !src_reg)
        begin
            store_b_reg[k_reg[AW-1:0]] <= merge_data;
        end
        rd_b0_reg <= store_b_reg[i_reg[AW-1:0]];
        rd_b1_reg <= store_b_reg[j_reg[AW-1:0]];
    end

    // Count elements, flag drops, walk passes, runs and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            src_reg      <= 1'b0;
            w_reg        <= '0;
            lo_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_out;
            if (cmd.load)
            begin
                if (store_room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.sort_init)
            begin
                w_reg   <= IW'(1);
                src_reg <= 1'b0;
            end
            if (cmd.run_first)
            begin
                lo_reg <= '0;
            end
            if (cmd.run_init)
            begin
                i_reg <= lo_reg;
                j_reg <= mid;
                k_reg <= lo_reg;
            end
            if (cmd.run_next)
            begin
                lo_reg <= lo_2w;
            end
            if (cmd.pass_end)
            begin
                w_reg   <= w_reg << 1;
                src_reg <= !src_reg;
            end
            if (cmd.merge_step)
            begin
                k_reg <= k_reg + IW'(1);
                if (take_left)
                begin
                    i_reg <= i_reg + IW'(1);
                end
                else
                begin
                    j_reg <= j_reg + IW'(1);
                end
            end
            if (cmd.emit_init)
            begin
                i_reg <= '0;
            end
            if (cmd.emit_out)
            begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.set_clear)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    // Hold the result word for its one strobe cycle
    always_ff @(posedge clk)
    begin
        if (cmd.emit_out)
        begin
            result_reg.sorted_value <= left_data;
            result_reg.end_of_set   <= stat.emit_last;
            result_reg.truncated    <= overflow_reg;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `MSORT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH))
    `MSORT_ASSERT(a_merge_in_run, clk, rst_n, cmd.merge_step |-> (k_reg < hi))
    `MSORT_ASSERT(a_emit_in_set, clk, rst_n, cmd.emit_out |-> (i_reg < n_ext))

endmodule

### hw/rtl/msort_ctrl.sv
`include "merge_sorter_core_assert.svh"

module msort_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last,
    input  msort_pkg::stat_t stat,
    output msort_pkg::cmd_t  cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_PASS,
        ST_RUN,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // Sequence load, merge passes and emission
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                if (start && last)
                begin
                    state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = ST_PASS;
            end
            ST_PASS:
            begin
                if (stat.pass_open)
                begin
                    cmd.run_first = 1'b1;
                    state_next    = ST_RUN;
                end
                else
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
            end
            ST_RUN:
            begin
                if (stat.run_open)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = ST_MERGE_RD;
                end
                else
                begin
                    cmd.pass_end = 1'b1;
                    state_next   = ST_PASS;
                end
            end
            ST_MERGE_RD:
            begin
                if (stat.merge_open)
                begin
                    state_next = ST_MERGE_WR;
                end
                else
                begin
                    cmd.run_next = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_MERGE_WR:
            begin
                cmd.merge_step = 1'b1;
                state_next     = ST_MERGE_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                cmd.emit_out = 1'b1;
                if (stat.emit_last)
                begin
                    cmd.set_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

    `MSORT_ASSERT(a_busy_state, clk, rst_n, busy_reg == (state_reg != ST_IDLE))
    `MSORT_ASSERT_NEXT(a_done_idle, clk, rst_n, cmd.set_clear, !busy_reg)

endmodule

### hw/rtl/merge_sorter_core.sv
// Merge sorter. Send one element word per start pulse while busy is low;
// the word marked last closes the set and the block goes busy. Elements
// beyond DEPTH are dropped and every result word of that set carries the
// truncated flag. The sort runs ceil(log2 n) merge passes over two
// ping-pong stores with registered reads; each merged element takes a
// read step, then a compare and write step; each run adds a step that
// sets the pointers and one that sees the run end, and each pass a step
// that tests the width. Emission then reads each element and presents
// it. Results leave in ascending order, one strobe cycle each, and
// cannot be stalled: the receiver must take every strobed word. busy
// drops in the cycle that carries the final word, so the next set may
// start loading in that cycle.
module merge_sorter_core #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  msort_pkg::item_t   item,
    output logic               busy,
    output logic               strobe,
    output msort_pkg::result_t result
);

    msort_pkg::cmd_t  cmd;
    msort_pkg::stat_t stat;

    msort_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (item.last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    msort_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

endmodule

### test/merge_sorter_core_test.sv
module merge_sorter_core_test;

    localparam int STORE_DEPTH   = 64;
    localparam int IDLE_LIMIT    = 6000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int PRINT_LIMIT   = 40;
    localparam int RANDOM_WORDS  = 100;

    // Value flavors for generated sets
    typedef enum int { VAL_WIDE, VAL_NARROW, VAL_EXTREME } val_mode_t;

    logic               clk;
    logic               rst_n;
    logic               start = 1'b0;
    msort_pkg::item_t   item  = '0;
    logic               busy;
    logic               strobe;
    msort_pkg::result_t result;

    merge_sorter_core #(
        .DEPTH (STORE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    msort_pkg::item_t   pending_words[$];
    msort_pkg::result_t sorted_words[$];
    logic signed [msort_pkg::DATA_W-1:0] set_values[$];
    bit      set_dropped;
    bit      word_taken;
    int      words_total;
    int      words_taken;
    int      error_count;
    int      idle_cycles;
    int      burst_left = 8;
    int      gap_left   = 0;

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Print a mismatch line, up to PRINT_LIMIT of them, and count it
    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Pick one element value of the given flavor
    function automatic logic signed [msort_pkg::DATA_W-1:0] pick_value(input val_mode_t mode);
        logic signed [msort_pkg::DATA_W-1:0] v;
        case (mode)
            VAL_NARROW:  v = $signed($urandom_range(0, 6)) - 3;
            VAL_EXTREME:
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(msort_pkg::DATA_W-1){1'b0}}};
                    1:       v = {1'b0, {(msort_pkg::DATA_W-1){1'b1}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 1;
                endcase
            default:     v = $urandom;
        endcase
        return v;
    endfunction

    // Queue a set of n words, the final one marked last
    task automatic queue_set(input int n, input val_mode_t mode);
        msort_pkg::item_t w;
        for (int i = 0; i < n; i++)
        begin
            w.value = pick_value(mode);
            w.last  = (i == n - 1);
            pending_words.push_back(w);
        end
        words_total += n;
    endtask

    // Queue a set with given values
    task automatic queue_values(input logic signed [msort_pkg::DATA_W-1:0] vals[$]);
        msort_pkg::item_t w;
        foreach (vals[i])
        begin
            w.value = vals[i];
            w.last  = (i == vals.size() - 1);
            pending_words.push_back(w);
        end
        words_total += vals.size();
    endtask

    // Absorb one accepted word; on a closing word sort the set and queue its results
    task automatic absorb_word(input msort_pkg::item_t w);
        logic signed [msort_pkg::DATA_W-1:0] key;
        msort_pkg::result_t r;
        int j;
        if (set_values.size() < STORE_DEPTH)
            set_values.push_back(w.value);
        else
            set_dropped = 1'b1;
        if (w.last)
        begin
            // insertion sort, ascending signed
            for (int i = 1; i < set_values.size(); i++)
            begin
                key = set_values[i];
                j = i;
                while (j > 0 && set_values[j-1] > key)
                begin
                    set_values[j] = set_values[j-1];
                    j--;
                end
                set_values[j] = key;
            end
            foreach (set_values[k])
            begin
                r.sorted_value = set_values[k];
                r.end_of_set   = (k == set_values.size() - 1);
                r.truncated    = set_dropped;
                sorted_words.push_back(r);
            end
            set_values.delete();
            set_dropped = 1'b0;
        end
    endtask

    // Fill the word queue, then wait for the run to drain
    initial
    begin
        logic signed [msort_pkg::DATA_W-1:0] vals[$];
        int n;
        int mode_pick;
        val_mode_t mode;

        rst_n = 1'b0;
        words_total = 0;

        // single element, extremes, ties, presorted and reversed sets
        vals = '{0};
        queue_values(vals);
        vals = '{32'sh7fffffff, 32'sh80000000};
        queue_values(vals);
        vals = '{-1, 0, 1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0};
        queue_values(vals);
        vals = '{1, 2, 3, 4};
        queue_values(vals);
        vals = '{4, 3, 2, 1};
        queue_values(vals);
        vals = '{5, 5, 5};
        queue_values(vals);

        // store filled, then one over with the closing word dropped
        queue_set(STORE_DEPTH + 1, VAL_WIDE);
        queue_set(2, VAL_EXTREME);

        // random small sets up to the word budget
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            mode_pick = $urandom_range(0, 2);
            mode = (mode_pick == 0) ? VAL_WIDE : (mode_pick == 1) ? VAL_NARROW : VAL_EXTREME;
            case ($urandom_range(0, 19))
                0, 1, 2, 3: queue_set($urandom_range(9, 20), mode);
                default:    queue_set($urandom_range(1, 8), mode);
            endcase
            n = words_total;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every word to go in and every result to come out
        while (words_taken != words_total)
            @(negedge clk);
        while (sorted_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sorted_words.size() != 0)
            report_error($sformatf("%0d results never arrived", sorted_words.size()));
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Drive words in bursts with random gaps; hold a word until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                item  <= pending_words.pop_front();
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Take accepted words, check strobed results, watch for a hang
    always @(posedge clk)
    begin
        msort_pkg::result_t want;
        word_taken = 1'b0;
        if (rst_n)
        begin
            idle_cycles++;
            if (start && !busy)
            begin
                word_taken = 1'b1;
                words_taken++;
                idle_cycles = 0;
                absorb_word(item);
            end
            if (strobe)
            begin
                idle_cycles = 0;
                if (sorted_words.size() == 0)
                    report_error($sformatf("unexpected result value %0d",
                                           result.sorted_value));
                else
                begin
                    want = sorted_words.pop_front();
                    if (result.sorted_value !== want.sorted_value)
                        report_error($sformatf("sorted_value %0d, want %0d",
                                               result.sorted_value, want.sorted_value));
                    if (result.end_of_set !== want.end_of_set)
                        report_error($sformatf("end_of_set %b, want %b on value %0d",
                                               result.end_of_set, want.end_of_set,
                                               want.sorted_value));
                    if (result.truncated !== want.truncated)
                        report_error($sformatf("truncated %b, want %b on value %0d",
                                               result.truncated, want.truncated,
                                               want.sorted_value));
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR @%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
